/* sv/sstamp_pkg.sv */
// ----------------------------------------------------------------------------
// sstamp_pkg
// Shared types, constants and the disc mask for the additive sprite stamper.
// ----------------------------------------------------------------------------
package sstamp_pkg;

    // Frame defaults
    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 256;

    // Disc geometry
    localparam int DISC_SIZE = 16;
    localparam int DISC_HALF = 8;

    // Widths: input coordinate fields, the widened working coordinate, mask offsets and pixels
    localparam int POS_W   = 11;
    localparam int COORD_W = 12;
    localparam int OFF_W   = 4;
    localparam int PIX_W   = 8;

    // Operation codes
    localparam logic OP_STAMP = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // One row per entry; bit (15 - c) set means mask column c is set
    localparam logic [DISC_SIZE-1:0] DISC_ROWS [DISC_SIZE] = '{
        16'h03C0, 16'h0FF0, 16'h1FF8, 16'h3FFC,
        16'h7FFE, 16'h7FFE, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'h7FFE, 16'h7FFE,
        16'h3FFC, 16'h1FF8, 16'h0FF0, 16'h03C0
    };

    // Pixel request from the sequencer to the pixel unit
    typedef struct packed {
        logic             valid;
        logic             rd;
        logic             mask_bit;
        logic [OFF_W-1:0] off_x;
        logic [OFF_W-1:0] off_y;
    } issue_t;

    // Read result leaving the pixel unit
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [PIX_W-1:0] value;
    } result_t;

    // Mask lookup: column c lives at bit (15 - c) of its row
    function automatic logic disc_bit(input logic [OFF_W-1:0] row,
                                      input logic [OFF_W-1:0] col);
        logic [DISC_SIZE-1:0] bits;
        bits = DISC_ROWS[row];
        return bits[~col];
    endfunction

endpackage

/* sv/additive_sprite_stamp_top.sv */
// ----------------------------------------------------------------------------
// additive_sprite_stamp_top
// Additive disc stamper over an 8-bit frame store with single-pixel reads.
//
//   channel   dir  ports                               transfer
//   s_        in   s_op, s_pos_x, s_pos_y              s_valid & s_ready
//   m_        out  m_pixel_value, m_in_frame           m_valid & m_ready
//
// A stamp walks all 256 mask positions through the shared pixel unit at one
// position per cycle, then waits for the pixel pipeline to drain.
// After reset the frame is cleared one pixel per cycle, all FRAME_WIDTH *
// FRAME_HEIGHT pixels (65536 by default), with s_ready low throughout.
// A stalled m_ready holds a finished read result; stamps proceed meanwhile.
// ----------------------------------------------------------------------------
module additive_sprite_stamp_top #(
    parameter int FRAME_WIDTH  = sstamp_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sstamp_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [sstamp_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [sstamp_pkg::POS_W-1:0] s_pos_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sstamp_pkg::PIX_W-1:0]        m_pixel_value,
    output logic                                m_in_frame
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PW     = sstamp_pkg::PIX_W;
    localparam int CW     = sstamp_pkg::COORD_W;

    sstamp_pkg::issue_t   issue;
    sstamp_pkg::result_t  result;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic                 pix_busy;
    logic                 out_busy;
    logic                 clr_en;
    logic [ADDR_W-1:0]    clr_addr;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [PW-1:0]        rd_data;
    logic                 pix_wr_en;
    logic [ADDR_W-1:0]    pix_wr_addr;
    logic [PW-1:0]        pix_wr_data;
    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [PW-1:0]        mem_wr_data;

    logic                 m_valid_reg;
    logic [PW-1:0]        m_pixel_value_reg;
    logic                 m_in_frame_reg;

    assign out_busy = m_valid_reg && !m_ready;

    sstamp_ctrl #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_pos_x  (s_pos_x),
        .s_pos_y  (s_pos_y),
        .out_busy (out_busy),
        .pix_busy (pix_busy),
        .issue    (issue),
        .base_x   (base_x),
        .base_y   (base_y),
        .clr_en   (clr_en),
        .clr_addr (clr_addr)
    );

    sstamp_pix #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_pix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .base_x  (base_x),
        .base_y  (base_y),
        .busy    (pix_busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (pix_wr_en),
        .wr_addr (pix_wr_addr),
        .wr_data (pix_wr_data),
        .result  (result)
    );

    // Clearing pass owns the write port until it finishes
    always_comb begin
        if (clr_en) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = pix_wr_en;
            mem_wr_addr = pix_wr_addr;
            mem_wr_data = pix_wr_data;
        end
    end

    sstamp_fbuf #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_fbuf (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: load a read result, drop it on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_pixel_value_reg <= result.value;
            m_in_frame_reg    <= result.hit;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_value_reg;
    assign m_in_frame    = m_in_frame_reg;

`ifndef SYNTH
    // A new result never overwrites one that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && m_valid_reg) |-> m_ready)
        else $error("read result overwrote a pending result");

    // The clearing pass and pixel write-back never share the write port
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_en |-> !pix_wr_en && !s_ready)
        else $error("pixel traffic during the clearing pass");
`endif

endmodule

/* sv/sstamp_fbuf.sv */
// ----------------------------------------------------------------------------
// sstamp_fbuf
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sstamp_fbuf #(
    parameter int FRAME_WIDTH  = sstamp_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sstamp_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] wr_addr,
    input  logic [sstamp_pkg::PIX_W-1:0]         wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] rd_addr,
    output logic [sstamp_pkg::PIX_W-1:0]         rd_data
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

    logic [sstamp_pkg::PIX_W-1:0] mem [DEPTH];
    logic [sstamp_pkg::PIX_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sstamp_pix.sv */
// ----------------------------------------------------------------------------
// sstamp_pix
// Shared pixel unit: offsets a base coordinate, clips it against the frame,
// forms the store address, reads the pixel and hands back either an
// incremented pixel for write-back or a read result.
// ----------------------------------------------------------------------------
module sstamp_pix #(
    parameter int FRAME_WIDTH  = sstamp_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sstamp_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  sstamp_pkg::issue_t                        issue,
    input  logic signed [sstamp_pkg::COORD_W-1:0]     base_x,
    input  logic signed [sstamp_pkg::COORD_W-1:0]     base_y,
    output logic                                      busy,
    output logic                                      rd_en,
    output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] rd_addr,
    input  logic [sstamp_pkg::PIX_W-1:0]              rd_data,
    output logic                                      wr_en,
    output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] wr_addr,
    output logic [sstamp_pkg::PIX_W-1:0]              wr_data,
    output sstamp_pkg::result_t                       result
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = $clog2(FRAME_WIDTH);
    localparam int YW     = $clog2(FRAME_HEIGHT);
    localparam int CW     = sstamp_pkg::COORD_W;
    localparam int OW     = sstamp_pkg::OFF_W;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 in_bounds;

    logic                 p1_valid_reg;
    logic                 p1_hit_reg;
    logic                 p1_rd_reg;
    logic [XW-1:0]        p1_x_reg;
    logic [YW-1:0]        p1_y_reg;
    logic [ADDR_W-1:0]    p1_addr;

    logic                 p2_valid_reg;
    logic                 p2_hit_reg;
    logic                 p2_rd_reg;
    logic [ADDR_W-1:0]    p2_addr_reg;

    // Offset and clip
    always_comb begin
        px = base_x + $signed({{(CW-OW){1'b0}}, issue.off_x});
        py = base_y + $signed({{(CW-OW){1'b0}}, issue.off_y});
        in_bounds = (px >= 0) && (px < $signed(CW'(FRAME_WIDTH)))
                 && (py >= 0) && (py < $signed(CW'(FRAME_HEIGHT)));
    end

    // Stage 1: clipped coordinate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue.valid;
        end
        p1_hit_reg <= issue.mask_bit && in_bounds;
        p1_rd_reg  <= issue.rd;
        p1_x_reg   <= px[XW-1:0];
        p1_y_reg   <= py[YW-1:0];
    end

    // Row-major address, then read request
    assign p1_addr = ADDR_W'(p1_y_reg) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(p1_x_reg);
    assign rd_en   = p1_valid_reg && p1_hit_reg;
    assign rd_addr = p1_addr;

    // Stage 2: pixel data arrives from the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
        end
        p2_hit_reg  <= p1_hit_reg;
        p2_rd_reg   <= p1_rd_reg;
        p2_addr_reg <= p1_addr;
    end

    // Write back the incremented pixel; the add wraps
    assign wr_en   = p2_valid_reg && p2_hit_reg && !p2_rd_reg;
    assign wr_addr = p2_addr_reg;
    assign wr_data = rd_data + sstamp_pkg::PIX_W'(1);

    // Read result: zero outside the frame
    always_comb begin
        result.valid = p2_valid_reg && p2_rd_reg;
        result.hit   = p2_hit_reg;
        result.value = p2_hit_reg ? rd_data : '0;
    end

    assign busy = p1_valid_reg || p2_valid_reg;

`ifndef SYNTH
    // A write-back never lands on the pixel being read in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write-back hit the same pixel");

    // Every issued request passes through stage 1 and reaches stage 2
    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        issue.valid |=> ##1 p2_valid_reg)
        else $error("issued pixel lost in the pipeline");
`endif

endmodule

/* sv/sstamp_ctrl.sv */
// ----------------------------------------------------------------------------
// sstamp_ctrl
// Sequencer: clears the frame after reset, takes one item at a time and
// walks the 16x16 mask (or a single pixel for a read) through the pixel unit.
// ----------------------------------------------------------------------------
module sstamp_ctrl #(
    parameter int FRAME_WIDTH  = sstamp_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sstamp_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_op,
    input  logic signed [sstamp_pkg::POS_W-1:0]       s_pos_x,
    input  logic signed [sstamp_pkg::POS_W-1:0]       s_pos_y,
    input  logic                                      out_busy,
    input  logic                                      pix_busy,
    output sstamp_pkg::issue_t                        issue,
    output logic signed [sstamp_pkg::COORD_W-1:0]     base_x,
    output logic signed [sstamp_pkg::COORD_W-1:0]     base_y,
    output logic                                      clr_en,
    output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] clr_addr
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = sstamp_pkg::COORD_W;
    localparam int OW     = sstamp_pkg::OFF_W;
    localparam int IDX_W  = 2 * OW;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]           state_reg,   state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]     idx_reg,     idx_next;
    logic                 op_reg,      op_next;
    logic signed [CW-1:0] base_x_reg,  base_x_next;
    logic signed [CW-1:0] base_y_reg,  base_y_next;
    logic signed [CW-1:0] pos_x_ext;
    logic signed [CW-1:0] pos_y_ext;
    logic                 accept;
    logic                 issue_go;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign pos_x_ext = CW'(s_pos_x);
    assign pos_y_ext = CW'(s_pos_y);

    // Hold a read until the output slot is free
    assign issue_go = (state_reg == ST_RUN) && !((op_reg == sstamp_pkg::OP_READ) && out_busy);

    // Pixel request
    always_comb begin
        issue.valid    = issue_go;
        issue.rd       = (op_reg == sstamp_pkg::OP_READ);
        issue.mask_bit = (op_reg == sstamp_pkg::OP_READ)
                       ? 1'b1 : sstamp_pkg::disc_bit(idx_reg[IDX_W-1:OW], idx_reg[OW-1:0]);
        issue.off_x    = (op_reg == sstamp_pkg::OP_READ) ? '0 : idx_reg[OW-1:0];
        issue.off_y    = (op_reg == sstamp_pkg::OP_READ) ? '0 : idx_reg[IDX_W-1:OW];
    end

    assign base_x   = base_x_reg;
    assign base_y   = base_y_reg;
    assign clr_en   = (state_reg == ST_CLEAR);
    assign clr_addr = clr_cnt_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        base_x_next  = base_x_reg;
        base_y_next  = base_y_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next  = s_op;
                    idx_next = '0;
                    if (s_op == sstamp_pkg::OP_READ) begin
                        base_x_next = pos_x_ext;
                        base_y_next = pos_y_ext;
                    end else begin
                        base_x_next = pos_x_ext - CW'(sstamp_pkg::DISC_HALF);
                        base_y_next = pos_y_ext - CW'(sstamp_pkg::DISC_HALF);
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue_go) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if ((op_reg == sstamp_pkg::OP_READ) || (idx_reg == '1)) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!pix_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            idx_reg     <= idx_next;
        end
    end

    // Item registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        base_x_reg <= base_x_next;
        base_y_reg <= base_y_next;
    end

`ifndef SYNTH
    // One item at a time: ready drops after each transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken while an item is in progress");

    // A read issues exactly one pixel request
    a_read_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue.valid && issue.rd) |=> !issue.valid)
        else $error("read issued more than one pixel");

    // No item is taken while the pixel pipeline still holds work
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(pix_busy && $past(state_reg) == ST_IDLE))
        else $error("pixel pipeline busy while idle");
`endif

endmodule
